>>> rtl/issb_pkg.sv
// Package with the constants and types shared by the subnet blocker files.
package issb_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int WALK_LIMIT      = 50;

    localparam int TDATA_IN_W  = 80;
    localparam int TDATA_OUT_W = 8;
    localparam int TUSER_IN_W  = 2;

    localparam logic [5:0]  MIN_FRAME      = 6'd34;
    localparam logic [5:0]  POS_TYPE_HI    = 6'd12;
    localparam logic [5:0]  POS_TYPE_LO    = 6'd13;
    localparam logic [5:0]  POS_SRC_FIRST  = 6'd26;
    localparam logic [5:0]  POS_SRC_LAST   = 6'd29;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    typedef enum logic [1:0] {
        OP_BYTE       = 2'd0,
        OP_WRITE      = 2'd1,
        OP_INVALIDATE = 2'd2,
        OP_UNUSED     = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_CMP  = 3'b100
    } t_state;

endpackage

>>> rtl/ipv4_source_subnet_blocker.sv
// Top level of the IPv4 source subnet blocker: frame parser, table and walk sequencer.
// Frame bytes and table commands arrive as items on the slave stream. A frame byte that is
// not the last one, a table write and a table invalidate are each handled in the cycle in
// which they are accepted. On the last byte of a frame the block gives a verdict on the
// master stream: frames shorter than 34 bytes or not of ethertype 0x0800 pass at once, the
// verdict being registered in the cycle after the last byte. Otherwise a sequencer walks the
// table from entry 0 with one shared mask-and-compare unit; each entry passes a read state
// for the registered memory read and then a compare state. The walk covers at most
// min(50, TABLE_DEPTH) entries and stops at the first invalid entry or at the first match,
// which drops the frame. The input stays not ready during the walk and while a verdict
// waits to be taken. Valid bits are cleared by reset at once; table contents are undefined
// until written, so no clearing pass is needed.
module ipv4_source_subnet_blocker #(
    parameter int TABLE_DEPTH = issb_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // From bit 0: frame_byte[7:0], entry_index[13:8], entry_address[45:14],
    // entry_mask[77:46], zero fill[79:78].
    input  logic [issb_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // From bit 0: opcode[1:0].
    input  logic [issb_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // From bit 0: drop_frame[0], zero fill[7:1].
    output logic [issb_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
    import issb_pkg::*;

    // Index width of the table and width of the walk counter, which can hold the depth.
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WALK_N = (WALK_LIMIT < TABLE_DEPTH) ? WALK_LIMIT : TABLE_DEPTH;
    localparam logic [CNT_W-1:0] WALK_END = CNT_W'(WALK_N);
    localparam logic [8:0]       DEPTH_9  = 9'(TABLE_DEPTH);

    // Unpacked input fields.
    t_opcode     in_op;
    logic [7:0]  in_byte;
    logic [5:0]  in_index;
    logic [31:0] in_addr;
    logic [31:0] in_mask;
    logic        in_accept;
    logic [8:0]  slot_ext;
    logic        slot_ok;

    assign in_op     = t_opcode'(s_axis_tuser[1:0]);
    assign in_byte   = s_axis_tdata[7:0];
    assign in_index  = s_axis_tdata[13:8];
    assign in_addr   = s_axis_tdata[45:14];
    assign in_mask   = s_axis_tdata[77:46];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign slot_ext  = {3'b000, in_index};
    assign slot_ok   = (slot_ext < DEPTH_9);

    // Control and frame state.
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_walk, n_walk;
    logic [5:0]        r_pos, n_pos;
    logic [15:0]       r_type, n_type;
    logic [31:0]       r_src, n_src;
    logic              r_out_valid, n_out_valid;
    logic              r_drop, n_drop;
    logic              r_valid [TABLE_DEPTH];

    // Table memory with a registered read port.
    logic [31:0] r_mem_addr [TABLE_DEPTH];
    logic [31:0] r_mem_mask [TABLE_DEPTH];
    logic [31:0] r_rd_addr;
    logic [31:0] r_rd_mask;

    logic [IDX_W-1:0] walk_idx;
    logic             walk_done;
    logic             hit;

    assign walk_idx  = r_walk[IDX_W-1:0];
    assign walk_done = (r_walk == WALK_END) || !r_valid[walk_idx];
    // The shared compare unit: masked source against masked entry address.
    assign hit       = ((r_src & r_rd_mask) == (r_rd_addr & r_rd_mask));

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_OUT_W-1){1'b0}}, r_drop};

    always_comb begin
        n_state     = r_state;
        n_walk      = r_walk;
        n_pos       = r_pos;
        n_type      = r_type;
        n_src       = r_src;
        n_out_valid = r_out_valid;
        n_drop      = r_drop;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (in_op == OP_BYTE)) begin
                    if (r_pos == POS_TYPE_HI) begin
                        n_type = {in_byte, r_type[7:0]};
                    end else if (r_pos == POS_TYPE_LO) begin
                        n_type = {r_type[15:8], in_byte};
                    end else if ((r_pos >= POS_SRC_FIRST) && (r_pos <= POS_SRC_LAST)) begin
                        n_src = {r_src[23:0], in_byte};
                    end
                    if (r_pos != MIN_FRAME) begin
                        n_pos = r_pos + 6'd1;
                    end
                    if (s_axis_tlast) begin
                        // The source is kept for the walk. Every frame long enough to be
                        // checked shifts in all four source bytes, so it never needs clearing.
                        n_pos  = '0;
                        n_type = '0;
                        n_walk = '0;
                        if ((r_pos >= (MIN_FRAME - 6'd1)) && (r_type == ETHERTYPE_IPV4)) begin
                            n_state = S_READ;
                        end else begin
                            n_out_valid = 1'b1;
                            n_drop      = 1'b0;
                        end
                    end
                end
            end
            S_READ: begin
                if (walk_done) begin
                    n_out_valid = 1'b1;
                    n_drop      = 1'b0;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (hit) begin
                    n_out_valid = 1'b1;
                    n_drop      = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_walk  = r_walk + 1'b1;
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_walk      <= '0;
            r_pos       <= '0;
            r_type      <= '0;
            r_src       <= '0;
            r_out_valid <= 1'b0;
            r_drop      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_walk      <= n_walk;
            r_pos       <= n_pos;
            r_type      <= n_type;
            r_src       <= n_src;
            r_out_valid <= n_out_valid;
            r_drop      <= n_drop;
        end
    end

    // Valid bits, one per entry, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (in_accept && slot_ok) begin
            if (in_op == OP_WRITE) begin
                r_valid[slot_ext[IDX_W-1:0]] <= 1'b1;
            end else if (in_op == OP_INVALIDATE) begin
                r_valid[slot_ext[IDX_W-1:0]] <= 1'b0;
            end
        end
    end

    // Table write port and registered read port for the walk.
    always_ff @(posedge i_clk) begin
        if (in_accept && slot_ok && (in_op == OP_WRITE)) begin
            r_mem_addr[slot_ext[IDX_W-1:0]] <= in_addr;
            r_mem_mask[slot_ext[IDX_W-1:0]] <= in_mask;
        end
        if (r_state == S_READ) begin
            r_rd_addr <= r_mem_addr[walk_idx];
            r_rd_mask <= r_mem_mask[walk_idx];
        end
    end

endmodule

>>> rtl/issb_checker.sv
// Port-level checker for the subnet blocker and its bind to the top level.
module issb_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [issb_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    input logic [issb_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [issb_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
    import issb_pkg::*;

    logic in_acc;
    logic frame_end_acc;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign frame_end_acc = in_acc && (s_axis_tuser == OP_BYTE) && s_axis_tlast;

    // A pending verdict holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("verdict changed or vanished while stalled");

    // No new item is taken while a verdict waits.
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a verdict is pending");

    // Only the last byte of a frame produces a verdict.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !frame_end_acc) |=> !m_axis_tvalid)
        else $error("verdict without a frame end");

    // The verdict is a single bit.
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TDATA_OUT_W-1:1] == '0))
        else $error("fill bits of the verdict are not zero");

endmodule

bind ipv4_source_subnet_blocker issb_checker u_issb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
